/* rtl/tbce_pkg.sv */
package tbce_pkg;

   // Data memory geometry.
   localparam int ADDR_BITS = 16;
   localparam int MEM_DEPTH = 1 << ADDR_BITS;

   // Channel widths.
   localparam int REQ_DATA_BITS = 32;
   localparam int RSP_DATA_BITS = 64;

   // The word that stops the machine until reset.
   localparam logic [31:0] EXIT_WORD = 32'hEA00_0000;

   // Operation codes in the top byte of the instruction word.
   typedef enum logic [7:0] {
      OP_STORE       = 8'h10,
      OP_LOAD_X      = 8'h11,
      OP_LOAD_Y      = 8'h12,
      OP_LOAD_Z      = 8'h13,
      OP_LOAD_A      = 8'h14,
      OP_CMP_IMM     = 8'h1A,
      OP_CMP_MEM     = 8'h1B,
      OP_JUMP        = 8'h20,
      OP_JUMP_EQ     = 8'h22,
      OP_CLEAR_FLAGS = 8'h40,
      OP_PRINT       = 8'h55
   } opcode_type;

   typedef logic [ADDR_BITS-1:0] mem_addr_type;

   // One write into the data memory.
   typedef struct packed {
      logic         en;
      mem_addr_type addr;
      logic [7:0]   data;
   } mem_wr_type;

   // Architectural result of one instruction.
   typedef struct packed {
      logic [15:0] next_fetch_address;
      logic        equal_flag;
      logic        print_valid;
      logic [7:0]  print_byte;
      logic        halted;
      logic [7:0]  accumulator_value;
      logic [7:0]  x_value;
      logic [7:0]  y_value;
      logic [7:0]  z_value;
   } result_type;

endpackage

/* rtl/tbce_dmem.sv */
module tbce_dmem (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  tbce_pkg::mem_addr_type rd_addr,
   output logic [7:0]            rd_data,
   input  tbce_pkg::mem_wr_type  wr,
   output logic                  clear_busy
);

   logic [7:0]             mem [tbce_pkg::MEM_DEPTH];
   logic [7:0]             rd_data_ff;
   logic                   clr_busy_ff, clr_busy_in;
   tbce_pkg::mem_addr_type clr_addr_ff, clr_addr_in;
   logic                   we;
   tbce_pkg::mem_addr_type waddr;
   logic [7:0]             wdata;

   // Clearing sweep: one entry per cycle after reset.
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + tbce_pkg::mem_addr_type'(1);
         if (&clr_addr_ff) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // The sweep owns the write port while it runs.
   assign we    = clr_busy_ff || wr.en;
   assign waddr = clr_busy_ff ? clr_addr_ff : wr.addr;
   assign wdata = clr_busy_ff ? 8'd0 : wr.data;

   // Single write port, registered read port (read returns the old byte).
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clr_busy_ff;

   // No instruction may store while the sweep is still running.
   a_no_store_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !wr.en)
      else $error("store issued during clearing sweep");

endmodule

/* rtl/tbce_exec.sv */
module tbce_exec (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 exec_en,
   input  logic [31:0]          instr,
   input  logic [7:0]           mem_byte,
   output tbce_pkg::result_type result,
   output tbce_pkg::mem_wr_type mem_wr
);

   logic [15:0] pc_ff, pc_in;
   logic [7:0]  a_ff, a_in;
   logic [7:0]  x_ff, x_in;
   logic [7:0]  y_ff, y_in;
   logic [7:0]  z_ff, z_in;
   logic        eq_ff, eq_in;
   logic        halt_ff, halt_in;
   logic [7:0]  op;
   logic [7:0]  b2;
   logic [7:0]  b1;
   logic [7:0]  b0;
   logic [15:0] store_word;
   logic [15:0] pc_jump;
   logic        is_store;
   logic        pv;
   logic [7:0]  pb;

   assign op         = instr[31:24];
   assign b2         = instr[23:16];
   assign b1         = instr[15:8];
   assign b0         = instr[7:0];
   assign store_word = {b1, b2};

   // Decode and execute one instruction against the register state.
   always_comb begin
      pc_in    = pc_ff;
      a_in     = a_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      eq_in    = eq_ff;
      halt_in  = halt_ff;
      pc_jump  = pc_ff;
      is_store = 1'b0;
      pv       = 1'b0;
      pb       = 8'd0;
      if (!halt_ff) begin
         if (instr == tbce_pkg::EXIT_WORD) begin
            halt_in = 1'b1;
         end else begin
            unique case (op)
               tbce_pkg::OP_STORE:       is_store = 1'b1;
               tbce_pkg::OP_LOAD_X:      x_in = b2;
               tbce_pkg::OP_LOAD_Y:      y_in = b2;
               tbce_pkg::OP_LOAD_Z:      z_in = b2;
               tbce_pkg::OP_LOAD_A:      a_in = b2;
               tbce_pkg::OP_CMP_IMM:     eq_in = eq_ff | (a_ff == b2);
               tbce_pkg::OP_CMP_MEM:     eq_in = eq_ff | (a_ff == mem_byte);
               tbce_pkg::OP_JUMP:        pc_jump = instr[23:8];
               tbce_pkg::OP_JUMP_EQ: begin
                  if (eq_ff) begin
                     pc_jump = instr[23:8];
                  end
               end
               tbce_pkg::OP_CLEAR_FLAGS: eq_in = 1'b0;
               tbce_pkg::OP_PRINT: begin
                  pv = 1'b1;
                  pb = b2;
               end
               default: ;
            endcase
            pc_in = pc_jump + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= '0;
         a_ff    <= '0;
         x_ff    <= '0;
         y_ff    <= '0;
         z_ff    <= '0;
         eq_ff   <= 1'b0;
         halt_ff <= 1'b0;
      end else if (exec_en) begin
         pc_ff   <= pc_in;
         a_ff    <= a_in;
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         eq_ff   <= eq_in;
         halt_ff <= halt_in;
      end
   end

   // Store write goes out in the same cycle the instruction executes.
   assign mem_wr.en   = exec_en && is_store;
   assign mem_wr.addr = store_word[tbce_pkg::ADDR_BITS-1:0];
   assign mem_wr.data = b0;

   assign result.next_fetch_address = pc_in;
   assign result.equal_flag         = eq_in;
   assign result.print_valid        = pv;
   assign result.print_byte         = pb;
   assign result.halted             = halt_in;
   assign result.accumulator_value  = a_in;
   assign result.x_value            = x_in;
   assign result.y_value            = y_in;
   assign result.z_value            = z_in;

   // Once halted the counter and registers are frozen.
   a_halt_freezes_pc: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> $stable(pc_ff) && halt_ff)
      else $error("program counter moved while halted");

   // A halted machine neither prints nor stores.
   a_halt_no_effect: assert property (@(posedge clock) disable iff (reset)
      halt_ff |-> !pv && !is_store)
      else $error("side effect while halted");

endmodule

/* rtl/toy_byte_cpu_execute.sv */
// Flow: an accepted instruction is held in the s1 register while its data memory byte is read
// (the read is registered at acceptance); it executes when the output register is free or
// draining, which loads its result into the output register for transfer on the rsp side.
// Throughput: one instruction per cycle unless the rsp side stalls; a compare right after a
// store to the same byte is served by a forwarding register, so no stall arises.
// Reset: the valid bits, counter, registers and flags clear, then a sweep zeroes all 65536
// bytes of data memory (2^ADDR_BITS), one byte per cycle, with req_tready held low throughout.
module toy_byte_cpu_execute (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] instruction_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [15:0] next_fetch_address, [16] equal_flag,
                                    // [17] print_valid, [25:18] print_byte, [26] halted,
                                    // [34:27] accumulator_value, [42:35] x_value,
                                    // [50:43] y_value, [58:51] z_value, [63:59] zero
);

   logic                   s1_valid_ff, s1_valid_in;
   logic [31:0]            s1_instr_ff;
   logic                   fwd_hit_ff, fwd_hit_in;
   logic [7:0]             fwd_byte_ff;
   logic                   out_valid_ff, out_valid_in;
   logic [63:0]            out_data_ff;
   logic                   accept;
   logic                   exec_en;
   logic                   clear_busy;
   logic [15:0]            cmp_word;
   tbce_pkg::mem_addr_type rd_addr;
   logic [7:0]             rd_data;
   logic [7:0]             mem_byte;
   tbce_pkg::mem_wr_type   mem_wr;
   tbce_pkg::result_type   result;

   // Handshake: execute when the output register is free or draining.
   assign exec_en    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !clear_busy && (!s1_valid_ff || exec_en);
   assign accept     = req_tvalid && req_tready;

   // Compare address is taken with B2 as the high byte.
   assign cmp_word = req_tdata[23:8];
   assign rd_addr  = cmp_word[tbce_pkg::ADDR_BITS-1:0];

   tbce_dmem u_dmem (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr         (mem_wr),
      .clear_busy (clear_busy)
   );

   // A store executing in the cycle of the read is not yet seen by the memory.
   assign fwd_hit_in = mem_wr.en && (mem_wr.addr == rd_addr);
   assign mem_byte   = fwd_hit_ff ? fwd_byte_ff : rd_data;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (exec_en) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_instr_ff <= req_tdata;
         fwd_hit_ff  <= fwd_hit_in;
         fwd_byte_ff <= mem_wr.data;
      end
   end

   tbce_exec u_exec (
      .clock    (clock),
      .reset    (reset),
      .exec_en  (exec_en),
      .instr    (s1_instr_ff),
      .mem_byte (mem_byte),
      .result   (result),
      .mem_wr   (mem_wr)
   );

   // Output register.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (exec_en) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_en) begin
         out_data_ff <= {5'd0,
                         result.z_value,
                         result.y_value,
                         result.x_value,
                         result.accumulator_value,
                         result.halted,
                         result.print_byte,
                         result.print_valid,
                         result.equal_flag,
                         result.next_fetch_address};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // No instruction enters while the memory is being cleared.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !accept)
      else $error("instruction accepted during clearing sweep");

   // Every executed instruction lands in the output register.
   a_exec_needs_slot: assert property (@(posedge clock) disable iff (reset)
      exec_en |=> out_valid_ff)
      else $error("executed result lost before output register");

endmodule

/* sim/toy_byte_cpu_execute_tb.sv */
module toy_byte_cpu_execute_tb;

   import tbce_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned REPORT_LIMIT = 10;

   // Kinds of entries in the stimulus queue.
   typedef enum logic [1:0] {
      SEQ_WORD,
      SEQ_PHASE,
      SEQ_HOLD,
      SEQ_DRAIN
   } step_kind_type;

   // How the two sides of the bus idle.
   typedef enum logic [1:0] {
      MODE_SLOW_RECEIVER,
      MODE_SLOW_SENDER,
      MODE_FULL_RATE
   } idle_mode_type;

   typedef struct packed {
      step_kind_type kind;
      idle_mode_type mode;
      logic [31:0]   word;
   } stimulus_step_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // [31:0] instruction_word
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;         // [15:0] next_fetch_address, [16] equal_flag,
                                   // [17] print_valid, [25:18] print_byte, [26] halted,
                                   // [34:27] accumulator_value, [42:35] x_value,
                                   // [50:43] y_value, [58:51] z_value

   stimulus_step_type instruction_queue[$];
   result_type        expected_results[$];
   idle_mode_type     idle_mode = MODE_SLOW_RECEIVER;
   int unsigned       words_planned = 0;
   int unsigned       hold_requests = 0;
   int unsigned       hold_served = 0;
   int unsigned       hold_left = 0;
   int unsigned       error_count = 0;
   int unsigned       cycle_count = 0;

   // Architectural state of the machine as the predictor sees it.
   logic [15:0] cpu_pc = '0;
   logic [7:0]  cpu_a = '0;
   logic [7:0]  cpu_x = '0;
   logic [7:0]  cpu_y = '0;
   logic [7:0]  cpu_z = '0;
   logic        cpu_equal = 1'b0;
   logic        cpu_halted = 1'b0;
   logic [7:0]  shadow_memory [0:MEM_DEPTH-1];

   toy_byte_cpu_execute u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   // Executes one instruction on the predicted state and queues the result it yields.
   task automatic execute_instruction(input logic [31:0] word);
      logic [7:0] op;
      logic [7:0] b2;
      logic [7:0] b1;
      logic [7:0] b0;
      logic       shows_print;
      logic [7:0] printed;
      result_type outcome;
      op = word[31:24];
      b2 = word[23:16];
      b1 = word[15:8];
      b0 = word[7:0];
      shows_print = 1'b0;
      printed = 8'h00;
      if (!cpu_halted) begin
         if (word == EXIT_WORD) begin
            // The exit word freezes the counter as well.
            cpu_halted = 1'b1;
         end else begin
            case (op)
               OP_STORE:       shadow_memory[mem_addr_type'({b1, b2})] = b0;
               OP_LOAD_X:      cpu_x = b2;
               OP_LOAD_Y:      cpu_y = b2;
               OP_LOAD_Z:      cpu_z = b2;
               OP_LOAD_A:      cpu_a = b2;
               OP_CMP_IMM:     if (cpu_a == b2) cpu_equal = 1'b1;
               OP_CMP_MEM: begin
                  // The compare address takes its bytes in the order opposite to a store.
                  if (cpu_a == shadow_memory[mem_addr_type'({b2, b1})]) cpu_equal = 1'b1;
               end
               OP_JUMP:        cpu_pc = {b2, b1};
               OP_JUMP_EQ:     if (cpu_equal) cpu_pc = {b2, b1};
               OP_CLEAR_FLAGS: cpu_equal = 1'b0;
               OP_PRINT: begin
                  shows_print = 1'b1;
                  printed = b2;
               end
               default: ;
            endcase
            cpu_pc = cpu_pc + 16'd1;
         end
      end
      outcome.next_fetch_address = cpu_pc;
      outcome.equal_flag = cpu_equal;
      outcome.print_valid = shows_print;
      outcome.print_byte = printed;
      outcome.halted = cpu_halted;
      outcome.accumulator_value = cpu_a;
      outcome.x_value = cpu_x;
      outcome.y_value = cpu_y;
      outcome.z_value = cpu_z;
      expected_results.push_back(outcome);
   endtask

   function automatic string describe_result(input result_type r);
      return $sformatf("pc=%h eq=%b pv=%b pb=%h halt=%b a=%h x=%h y=%h z=%h",
                       r.next_fetch_address, r.equal_flag, r.print_valid, r.print_byte,
                       r.halted, r.accumulator_value, r.x_value, r.y_value, r.z_value);
   endfunction

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
         $display("ERROR at cycle %0d: %s", cycle_count, msg);
      end
   endtask

   task automatic plan_word(input logic [31:0] word);
      instruction_queue.push_back('{kind: SEQ_WORD, mode: MODE_FULL_RATE, word: word});
      words_planned++;
   endtask

   task automatic plan_control(input step_kind_type kind, input idle_mode_type mode);
      instruction_queue.push_back('{kind: kind, mode: mode, word: 32'h0});
   endtask

   // One random program fragment: mostly well-formed sequences, some noise.
   task automatic plan_random_burst();
      int unsigned pick;
      logic [15:0] addr;
      logic [7:0]  value;
      logic [31:0] noise;
      opcode_type  op;
      pick = $urandom_range(99);
      if (pick < 45) begin
         // Store a byte, then compare A against it and branch on the outcome.
         if ($urandom_range(3) == 0) begin
            addr = 16'($urandom());
         end else begin
            addr = {8'($urandom_range(3)), 8'($urandom_range(3))};
         end
         value = 8'($urandom());
         if ($urandom_range(1) == 1) plan_word({OP_CLEAR_FLAGS, 24'($urandom())});
         if ($urandom_range(1) == 1) begin
            plan_word({OP_LOAD_A, ($urandom_range(4) == 0) ? 8'($urandom()) : value,
                       16'($urandom())});
            plan_word({OP_STORE, addr[7:0], addr[15:8], value});
         end else begin
            plan_word({OP_STORE, addr[7:0], addr[15:8], value});
            plan_word({OP_LOAD_A, ($urandom_range(4) == 0) ? 8'($urandom()) : value,
                       16'($urandom())});
         end
         if ($urandom_range(4) == 0) begin
            case ($urandom_range(3))
               0:       plan_word({OP_LOAD_X, 24'($urandom())});
               1:       plan_word({OP_LOAD_Y, 24'($urandom())});
               2:       plan_word({OP_LOAD_Z, 24'($urandom())});
               default: plan_word({OP_PRINT, 24'($urandom())});
            endcase
         end
         if ($urandom_range(4) == 0) begin
            // Bytes swapped: reads the store's mirror address instead.
            plan_word({OP_CMP_MEM, addr[7:0], addr[15:8], 8'($urandom())});
         end else begin
            plan_word({OP_CMP_MEM, addr[15:8], addr[7:0], 8'($urandom())});
         end
         plan_word({OP_JUMP_EQ, 24'($urandom())});
      end else if (pick < 65) begin
         // Compare with an immediate and branch.
         value = 8'($urandom());
         if ($urandom_range(2) == 0) value = {8{value[0]}};
         if ($urandom_range(1) == 1) plan_word({OP_CLEAR_FLAGS, 24'($urandom())});
         plan_word({OP_LOAD_A, value, 16'($urandom())});
         plan_word({OP_CMP_IMM,
                    ($urandom_range(3) == 0) ? value ^ 8'($urandom_range(255, 1)) : value,
                    16'($urandom())});
         plan_word({OP_JUMP_EQ, 24'($urandom())});
      end else if (pick < 85) begin
         // Any defined operation with random operand bytes.
         op = OP_STORE;
         op = op.first();
         repeat ($urandom_range(10)) op = op.next();
         plan_word({op, 24'($urandom())});
      end else begin
         // Noise, part of it next to the exit word but never equal to it.
         noise = $urandom();
         if ($urandom_range(3) == 0) noise[31:24] = EXIT_WORD[31:24];
         if (noise == EXIT_WORD) noise[0] = 1'b1;
         plan_word(noise);
      end
   endtask

   // Driver: offers queued instructions and predicts each accepted transfer.
   always @(posedge clock) begin : driver_blk
      idle_mode_type     mode_now;
      stimulus_step_type step;
      logic              blocked;
      int unsigned       idle_pct;
      mode_now = idle_mode;
      blocked = 1'b0;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            execute_instruction(req_tdata);
         end
         if (!req_tvalid || req_tready) begin
            // Act on control entries at the head of the queue.
            while (!blocked && instruction_queue.size() > 0 &&
                   instruction_queue[0].kind != SEQ_WORD) begin
               case (instruction_queue[0].kind)
                  SEQ_PHASE: begin
                     mode_now = instruction_queue[0].mode;
                     void'(instruction_queue.pop_front());
                  end
                  SEQ_HOLD: begin
                     hold_requests <= hold_requests + 1;
                     void'(instruction_queue.pop_front());
                  end
                  SEQ_DRAIN: begin
                     if (expected_results.size() == 0) begin
                        void'(instruction_queue.pop_front());
                     end else begin
                        blocked = 1'b1;
                     end
                  end
                  default: blocked = 1'b1;
               endcase
            end
            idle_pct = (mode_now == MODE_SLOW_RECEIVER) ? 6 :
                       (mode_now == MODE_SLOW_SENDER) ? 85 : 0;
            if (!blocked && instruction_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
               step = instruction_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= step.word;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         idle_mode <= mode_now;
      end
   end

   // Long receiver hold-off, started on request from the stimulus queue.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         hold_left <= HOLD_CYCLES;
         hold_served <= hold_served + 1;
      end
   end

   // Monitor: checks every result transfer against the oldest prediction.
   always @(posedge clock) begin : monitor_blk
      result_type  got;
      result_type  want;
      int unsigned idle_pct;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.next_fetch_address = rsp_tdata[15:0];
            got.equal_flag = rsp_tdata[16];
            got.print_valid = rsp_tdata[17];
            got.print_byte = rsp_tdata[25:18];
            got.halted = rsp_tdata[26];
            got.accumulator_value = rsp_tdata[34:27];
            got.x_value = rsp_tdata[42:35];
            got.y_value = rsp_tdata[50:43];
            got.z_value = rsp_tdata[58:51];
            if (expected_results.size() == 0) begin
               note_error({"result with nothing expected: ", describe_result(got)});
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  note_error({"expected ", describe_result(want), " got ", describe_result(got)});
               end
            end
         end
         idle_pct = (idle_mode == MODE_SLOW_RECEIVER) ? 85 :
                    (idle_mode == MODE_SLOW_SENDER) ? 6 : 0;
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < MEM_DEPTH; i++) shadow_memory[i] = 8'h00;

      // Directed program: register extremes, flag behavior, counter wrap, both
      // address byte orders, a compare right after a store, unknown opcodes.
      plan_control(SEQ_PHASE, MODE_SLOW_RECEIVER);
      plan_word({OP_LOAD_X, 24'hFF_0000});
      plan_word({OP_LOAD_Y, 24'hA5_FFFF});
      plan_word({OP_LOAD_Z, 24'h5A_0000});
      plan_word({OP_LOAD_A, 24'hFF_0000});
      plan_word({OP_JUMP_EQ, 24'hFF_FF00});
      plan_word({OP_CMP_IMM, 24'h00_0000});
      plan_word({OP_CMP_IMM, 24'hFF_0000});
      plan_word({OP_CMP_IMM, 24'h7E_0000});
      plan_word({OP_JUMP_EQ, 24'hFF_FF00});
      plan_word({OP_JUMP, 24'hFF_FE00});
      plan_word({OP_PRINT, 24'hFF_1234});
      plan_word({OP_PRINT, 24'h00_FFFF});
      plan_word({OP_CLEAR_FLAGS, 24'hFF_FFFF});
      plan_word({OP_LOAD_A, 24'h3C_0000});
      plan_word({OP_CMP_MEM, 24'h34_1200});
      plan_word({OP_STORE, 24'hFF_FFFF});
      plan_word({OP_STORE, 24'h34_123C});
      plan_word({OP_CMP_MEM, 24'h12_3400});
      plan_word({OP_CLEAR_FLAGS, 24'h00_0000});
      plan_word({OP_LOAD_A, 24'hFF_0000});
      plan_word({OP_CMP_MEM, 24'hFF_FF00});
      plan_word({OP_JUMP, 24'h00_0000});
      plan_word(32'h0000_0000);
      plan_word(32'hFFFF_FFFF);
      plan_word(EXIT_WORD | 32'h1);
      plan_word({OP_LOAD_X, 24'h00_FFFF});

      // Random part in three idling phases, with two drains and a long hold-off.
      while (words_planned < 420) plan_random_burst();
      plan_control(SEQ_DRAIN, MODE_FULL_RATE);
      plan_control(SEQ_PHASE, MODE_SLOW_SENDER);
      while (words_planned < 630) plan_random_burst();
      plan_control(SEQ_DRAIN, MODE_FULL_RATE);
      while (words_planned < 840) plan_random_burst();
      plan_control(SEQ_PHASE, MODE_FULL_RATE);
      while (words_planned < 950) plan_random_burst();
      plan_control(SEQ_HOLD, MODE_FULL_RATE);
      while (words_planned < 1250) plan_random_burst();

      // Halt, then words that must leave the held state untouched.
      plan_word(EXIT_WORD);
      plan_word({OP_PRINT, 24'hAA_0000});
      plan_word({OP_LOAD_A, 24'h77_0000});
      plan_word(EXIT_WORD);
      plan_word({OP_JUMP, 24'h12_3400});

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (instruction_queue.size() > 0 || req_tvalid || expected_results.size() > 0) begin
         @(negedge clock);
      end
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
